>>> design/shc_pkg.sv
// shared types, constants and the half-step pattern table of the stepper sequencer
// used by shc_step_logic and stepper_half_step_controller; no dependencies
`default_nettype none

package shc_pkg;

  localparam int STEP_COUNT_BITS = 24;
  localparam int DELAY_BITS      = 16;
  localparam int PHASE_BITS      = 3;
  localparam int COIL_BITS       = 4;
  localparam int FUNC_BITS       = 3;
  localparam int CFG_INDEX_BITS  = 1;
  localparam int CFG_DATA_BITS   = DELAY_BITS;

  localparam logic [DELAY_BITS-1:0] STEP_DELAY_RESET = DELAY_BITS'(2);

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_TICK    = 3'd0,
    FUNC_MOVE    = 3'd1,
    FUNC_STOP    = 3'd2,
    FUNC_STEP    = 3'd3,
    FUNC_RELEASE = 3'd4
  } shc_func_e;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_DELAY    = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DRIVER_ENABLE = 1'b1;

  typedef struct packed {
    logic [DELAY_BITS-1:0] step_delay;
    logic                  driver_enable;
  } shc_cfg_t;

  typedef struct packed {
    logic [FUNC_BITS-1:0]       func;
    logic [STEP_COUNT_BITS-1:0] step_count;
    logic                       step_direction;
  } shc_item_t;

  typedef struct packed {
    logic [PHASE_BITS-1:0]      phase;
    logic [COIL_BITS-1:0]       coil;
    logic                       running;
    logic                       dir;
    logic [STEP_COUNT_BITS-1:0] total;
    logic [STEP_COUNT_BITS-1:0] done;
    logic [DELAY_BITS-1:0]      delay_left;
  } shc_state_t;

  typedef struct packed {
    logic [COIL_BITS-1:0]       coil_pattern;
    logic                       busy_res;
    logic [STEP_COUNT_BITS-1:0] steps_completed;
    logic [STEP_COUNT_BITS-1:0] steps_requested;
    logic                       moving_direction;
    logic                       cmd_accepted;
    logic                       move_finished;
  } shc_result_t;

  // half-step drive pattern, bit0 is the first coil
  function automatic logic [COIL_BITS-1:0] half_step_pattern(input logic [PHASE_BITS-1:0] ph);
    logic [COIL_BITS-1:0] pat;
    case (ph)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

>>> design/shc_step_logic.sv
// next-state and result logic for one event item of the stepper sequencer
// depends on shc_pkg
`default_nettype none

module shc_step_logic (
  input  shc_pkg::shc_cfg_t    cfg_i,
  input  shc_pkg::shc_state_t  state_i,
  input  shc_pkg::shc_item_t   item_i,
  output shc_pkg::shc_state_t  state_o,
  output shc_pkg::shc_result_t result_o
);
  import shc_pkg::*;

  logic [DELAY_BITS-1:0]      reload;
  logic [STEP_COUNT_BITS-1:0] done_inc;
  logic [PHASE_BITS-1:0]      phase_up;
  logic [PHASE_BITS-1:0]      phase_dn;
  logic                       step_en;
  logic                       step_dir;
  logic                       accepted;
  logic                       finished;
  shc_state_t                 nxt;

  // zero delay acts as one
  assign reload   = (cfg_i.step_delay == '0) ? DELAY_BITS'(1) : cfg_i.step_delay;
  assign done_inc = state_i.done + STEP_COUNT_BITS'(1);
  assign phase_up = state_i.phase + PHASE_BITS'(1);
  assign phase_dn = state_i.phase - PHASE_BITS'(1);

  always_comb begin
    nxt      = state_i;
    step_en  = 1'b0;
    step_dir = state_i.dir;
    accepted = 1'b0;
    finished = 1'b0;
    case (shc_func_e'(item_i.func))
      FUNC_TICK: begin
        if (state_i.running) begin
          if (state_i.delay_left <= DELAY_BITS'(1)) begin
            if (done_inc == state_i.total) begin
              nxt.running    = 1'b0;
              nxt.done       = '0;
              nxt.delay_left = '0;
              finished       = 1'b1;
            end else begin
              nxt.done       = done_inc;
              step_en        = 1'b1;
              nxt.delay_left = reload;
            end
          end else begin
            nxt.delay_left = state_i.delay_left - DELAY_BITS'(1);
          end
        end
      end
      FUNC_MOVE: begin
        if (cfg_i.driver_enable && !state_i.running) begin
          accepted  = 1'b1;
          nxt.dir   = item_i.step_direction;
          nxt.total = item_i.step_count;
          nxt.done  = '0;
          if (item_i.step_count == '0) begin
            finished       = 1'b1;
            nxt.delay_left = '0;
          end else begin
            nxt.running    = 1'b1;
            step_en        = 1'b1;
            step_dir       = item_i.step_direction;
            nxt.delay_left = reload;
          end
        end
      end
      FUNC_STOP: begin
        nxt.running    = 1'b0;
        nxt.done       = '0;
        nxt.delay_left = '0;
        if (cfg_i.driver_enable) begin
          nxt.coil = '0;
        end
      end
      FUNC_STEP: begin
        if (cfg_i.driver_enable) begin
          accepted = 1'b1;
          step_en  = 1'b1;
          step_dir = item_i.step_direction;
        end
      end
      FUNC_RELEASE: begin
        if (cfg_i.driver_enable) begin
          nxt.coil = '0;
        end
      end
      default: begin
      end
    endcase

    // a step moves the phase only while the driver is enabled
    if (step_en && cfg_i.driver_enable) begin
      nxt.phase = step_dir ? phase_dn : phase_up;
      nxt.coil  = half_step_pattern(nxt.phase);
    end
  end

  assign state_o = nxt;

  assign result_o.coil_pattern     = nxt.coil;
  assign result_o.busy_res         = nxt.running;
  assign result_o.steps_completed  = nxt.done;
  assign result_o.steps_requested  = nxt.total;
  assign result_o.moving_direction = nxt.dir;
  assign result_o.cmd_accepted     = accepted;
  assign result_o.move_finished    = finished;

endmodule

`default_nettype wire

>>> design/stepper_half_step_controller.sv
// top level of the half-step stepper sequencer: input register, motion state, result register
// depends on shc_pkg and shc_step_logic
//
// usage
//   event items (func, step_count, step_direction) arrive on a valid/ready channel;
//   a transfer happens when in_valid_i and in_ready_o are both high
//   each event gives exactly one result on the output valid/ready channel
//   an event transferred into the input register moves on to the output register
//   once that register can take a result, and out_valid_o rises with that load
//   throughput: one event per cycle while out_ready_i is high; the input and output
//   registers are separate stages, so a new event is taken while a result waits
//   stall: when out_ready_i is low the result is held, the input register fills,
//   and in_ready_o drops only once both stages are occupied
//   reset: rst_ni low clears the motion state (phase 0, coils off, no move),
//   empties both stages, and loads step_delay 2 with the driver disabled
//   configuration: cfg_we_i writes step_delay (index 0) or driver_enable (index 1);
//   writes are expected only while the block is idle
`default_nettype none

module stepper_half_step_controller (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // configuration write port
  input  wire                                  cfg_we_i,
  input  wire  [shc_pkg::CFG_INDEX_BITS-1:0]   cfg_index_i,
  input  wire  [shc_pkg::CFG_DATA_BITS-1:0]    cfg_data_i,
  // event channel
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire  [shc_pkg::FUNC_BITS-1:0]        func_i,
  input  wire  [shc_pkg::STEP_COUNT_BITS-1:0]  step_count_i,
  input  wire                                  step_direction_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic [shc_pkg::COIL_BITS-1:0]        coil_pattern_o,
  output logic                                 busy_res_o,
  output logic [shc_pkg::STEP_COUNT_BITS-1:0]  steps_completed_o,
  output logic [shc_pkg::STEP_COUNT_BITS-1:0]  steps_requested_o,
  output logic                                 moving_direction_o,
  output logic                                 cmd_accepted_o,
  output logic                                 move_finished_o
);
  import shc_pkg::*;

  // configuration registers
  shc_cfg_t    cfg_q;

  // input stage
  logic        item_valid_q;
  shc_item_t   item_q;

  // motion state
  shc_state_t  state_q;
  shc_state_t  state_d;

  // output stage
  logic        out_valid_q;
  shc_result_t result_q;
  shc_result_t result_d;

  logic        out_load;
  logic        item_fire;
  logic        in_xfer;

  // output register can take a new result when empty or being drained
  assign out_load  = !out_valid_q || out_ready_i;
  assign item_fire = item_valid_q && out_load;
  assign in_ready_o = !item_valid_q || out_load;
  assign in_xfer   = in_valid_i && in_ready_o;

  // config decode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_delay    <= STEP_DELAY_RESET;
      cfg_q.driver_enable <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_STEP_DELAY:    cfg_q.step_delay    <= cfg_data_i[DELAY_BITS-1:0];
        CFG_DRIVER_ENABLE: cfg_q.driver_enable <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_xfer) begin
      item_valid_q <= 1'b1;
    end else if (out_load) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.func           <= func_i;
      item_q.step_count     <= step_count_i;
      item_q.step_direction <= step_direction_i;
    end
  end

  // per-event update
  shc_step_logic u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // motion state advances once per processed event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (item_fire) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (item_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign coil_pattern_o     = result_q.coil_pattern;
  assign busy_res_o         = result_q.busy_res;
  assign steps_completed_o  = result_q.steps_completed;
  assign steps_requested_o  = result_q.steps_requested;
  assign moving_direction_o = result_q.moving_direction;
  assign cmd_accepted_o     = result_q.cmd_accepted;
  assign move_finished_o    = result_q.move_finished;

endmodule

`default_nettype wire

>>> design/shc_checker.sv
// port-level assertions for the stepper sequencer, bound to the top level
// depends on shc_pkg and stepper_half_step_controller
`default_nettype none

module shc_checker (
  input wire                                 clk_i,
  input wire                                 rst_ni,
  input wire                                 in_valid_i,
  input wire                                 in_ready_o,
  input wire                                 out_valid_o,
  input wire                                 out_ready_i,
  input wire [shc_pkg::COIL_BITS-1:0]        coil_pattern_o,
  input wire                                 busy_res_o,
  input wire [shc_pkg::STEP_COUNT_BITS-1:0]  steps_completed_o,
  input wire                                 move_finished_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its coil drive
  a_coil_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(coil_pattern_o))
    else $error("coil pattern changed while stalled");

  // a finishing move is no longer busy
  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && move_finished_o |-> !busy_res_o && (steps_completed_o == '0))
    else $error("finished move still shows progress");

  // progress is cleared whenever no move runs
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |-> (steps_completed_o == '0))
    else $error("idle result with nonzero progress");

  // input side never blocks while the result side is free
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind stepper_half_step_controller shc_checker u_shc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .coil_pattern_o    (coil_pattern_o),
  .busy_res_o        (busy_res_o),
  .steps_completed_o (steps_completed_o),
  .move_finished_o   (move_finished_o)
);

`default_nettype wire

>>> bench/shc_motion_checker.sv
`timescale 1ns / 1ps
// checker for the half-step stepper sequencer: predicts the status of every event transfer
// and compares it field by field with each result transfer; depends on shc_pkg

module shc_motion_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [shc_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [shc_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [shc_pkg::FUNC_BITS-1:0]       func_i,
  input  logic [shc_pkg::STEP_COUNT_BITS-1:0] step_count_i,
  input  logic                                step_direction_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [shc_pkg::COIL_BITS-1:0]       coil_pattern_i,
  input  logic                                busy_res_i,
  input  logic [shc_pkg::STEP_COUNT_BITS-1:0] steps_completed_i,
  input  logic [shc_pkg::STEP_COUNT_BITS-1:0] steps_requested_i,
  input  logic                                moving_direction_i,
  input  logic                                cmd_accepted_i,
  input  logic                                move_finished_i,
  output int                                  fail_count_o,
  output int                                  pending_o,
  output int                                  results_o,
  output int                                  finished_o
);
  import shc_pkg::*;

  // coil drive per phase, phase 0 in the low nibble
  localparam logic [31:0] HALF_STEP_COILS = 32'h98C4_6231;

  shc_state_t            motor;
  logic [DELAY_BITS-1:0] step_delay_q;
  logic                  drive_on;
  shc_result_t           status_q [$];
  shc_result_t           want;
  shc_item_t             ev;

  function automatic logic [DELAY_BITS-1:0] delay_reload();
    return (step_delay_q == '0) ? DELAY_BITS'(1) : step_delay_q;
  endfunction

  task automatic take_half_step(input logic dir);
    if (drive_on) begin
      motor.phase = dir ? motor.phase - 1'b1 : motor.phase + 1'b1;
      motor.coil  = HALF_STEP_COILS[{motor.phase, 2'b00} +: COIL_BITS];
    end
  endtask

  task automatic advance_motion(input shc_item_t item, output shc_result_t res);
    logic taken;
    logic completed;
    taken     = 1'b0;
    completed = 1'b0;
    case (item.func)
      FUNC_TICK: begin
        if (motor.running) begin
          if (motor.delay_left <= 1) begin
            motor.done = motor.done + 1'b1;
            if (motor.done == motor.total) begin
              motor.running    = 1'b0;
              motor.done       = '0;
              motor.delay_left = '0;
              completed        = 1'b1;
            end else begin
              take_half_step(motor.dir);
              motor.delay_left = delay_reload();
            end
          end else begin
            motor.delay_left = motor.delay_left - 1'b1;
          end
        end
      end
      FUNC_MOVE: begin
        if (drive_on && !motor.running) begin
          taken       = 1'b1;
          motor.dir   = item.step_direction;
          motor.total = item.step_count;
          motor.done  = '0;
          if (item.step_count == '0) begin
            completed        = 1'b1;
            motor.delay_left = '0;
          end else begin
            motor.running = 1'b1;
            take_half_step(item.step_direction);
            motor.delay_left = delay_reload();
          end
        end
      end
      FUNC_STOP: begin
        motor.running    = 1'b0;
        motor.done       = '0;
        motor.delay_left = '0;
        if (drive_on) motor.coil = '0;
      end
      FUNC_STEP: begin
        if (drive_on) begin
          taken = 1'b1;
          take_half_step(item.step_direction);
        end
      end
      FUNC_RELEASE: begin
        if (drive_on) motor.coil = '0;
      end
      default: ;
    endcase
    res.coil_pattern     = motor.coil;
    res.busy_res         = motor.running;
    res.steps_completed  = motor.done;
    res.steps_requested  = motor.total;
    res.moving_direction = motor.dir;
    res.cmd_accepted     = taken;
    res.move_finished    = completed;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      motor        = '0;
      step_delay_q = STEP_DELAY_RESET;
      drive_on     = 1'b0;
      status_q.delete();
      fail_count_o = 0;
      results_o    = 0;
      finished_o   = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_STEP_DELAY) step_delay_q = cfg_data_i;
        else if (cfg_index_i == CFG_DRIVER_ENABLE) drive_on = cfg_data_i[0];
      end
      // compare before predicting: a result never belongs to an event taken at this edge
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (status_q.size() == 0) begin
          $error("result transfer with nothing expected, coil_pattern 0x%0h", coil_pattern_i);
          fail_count_o++;
        end else begin
          want = status_q.pop_front();
          check_field("coil_pattern", want.coil_pattern, coil_pattern_i);
          check_field("busy_res", want.busy_res, busy_res_i);
          check_field("steps_completed", want.steps_completed, steps_completed_i);
          check_field("steps_requested", want.steps_requested, steps_requested_i);
          check_field("moving_direction", want.moving_direction, moving_direction_i);
          check_field("cmd_accepted", want.cmd_accepted, cmd_accepted_i);
          check_field("move_finished", want.move_finished, move_finished_i);
          if (want.move_finished) finished_o++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        ev.func           = func_i;
        ev.step_count     = step_count_i;
        ev.step_direction = step_direction_i;
        advance_motion(ev, want);
        status_q.push_back(want);
      end
    end
    pending_o = status_q.size();
  end

endmodule

>>> bench/tb_stepper_half_step_controller.sv
`timescale 1ns / 1ps
// testbench top for stepper_half_step_controller: directed events, then random move sequences,
// step bursts and noise under three idle mixes; depends on shc_pkg, shc_motion_checker, the design

module tb_stepper_half_step_controller;
  import shc_pkg::*;

  localparam int RANDOM_EVENTS  = 1800;
  localparam int SEGMENT_EVENTS = RANDOM_EVENTS / 3;
  localparam int CYCLE_LIMIT    = 200000;

  // func codes the block leaves undefined
  localparam int FUNC_SPARE_FIRST = 5;
  localparam int FUNC_SPARE_LAST  = 7;

  localparam logic [STEP_COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [CFG_DATA_BITS-1:0]   DELAY_MAX = '1;
  localparam logic [CFG_DATA_BITS-1:0]   CFG_ON    = CFG_DATA_BITS'(1);
  localparam logic [CFG_DATA_BITS-1:0]   CFG_OFF   = '0;
  localparam logic DIR_CW  = 1'b0;
  localparam logic DIR_CCW = 1'b1;

  // clock, reset and stimulus, all known from time zero
  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       cfg_we    = 1'b0;
  logic [CFG_INDEX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]   cfg_data  = '0;
  logic                       ev_valid  = 1'b0;
  logic [FUNC_BITS-1:0]       ev_func   = '0;
  logic [STEP_COUNT_BITS-1:0] ev_count  = '0;
  logic                       ev_dir    = 1'b0;
  logic                       res_ready = 1'b0;

  // block outputs
  logic                       ev_ready;
  logic                       res_valid;
  logic [COIL_BITS-1:0]       coil_pattern;
  logic                       busy;
  logic [STEP_COUNT_BITS-1:0] steps_completed;
  logic [STEP_COUNT_BITS-1:0] steps_requested;
  logic                       moving_direction;
  logic                       cmd_accepted;
  logic                       move_finished;

  // checker status
  int fail_count;
  int pending;
  int results_seen;
  int moves_finished;

  // stimulus bookkeeping
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int unsigned cycles        = 0;
  int unsigned events_sent   = 0;
  int unsigned random_base;
  int unsigned seg, pick, steps, ticks, span, abort_at, n, j;
  int          spare;
  logic [CFG_DATA_BITS-1:0] delay_setting = STEP_DELAY_RESET;
  logic                     driver_on     = 1'b0;

  always #1 clk = ~clk;

  stepper_half_step_controller dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (ev_valid),
    .in_ready_o         (ev_ready),
    .func_i             (ev_func),
    .step_count_i       (ev_count),
    .step_direction_i   (ev_dir),
    .out_valid_o        (res_valid),
    .out_ready_i        (res_ready),
    .coil_pattern_o     (coil_pattern),
    .busy_res_o         (busy),
    .steps_completed_o  (steps_completed),
    .steps_requested_o  (steps_requested),
    .moving_direction_o (moving_direction),
    .cmd_accepted_o     (cmd_accepted),
    .move_finished_o    (move_finished)
  );

  shc_motion_checker u_motion_chk (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (ev_valid),
    .in_ready_i         (ev_ready),
    .func_i             (ev_func),
    .step_count_i       (ev_count),
    .step_direction_i   (ev_dir),
    .out_valid_i        (res_valid),
    .out_ready_i        (res_ready),
    .coil_pattern_i     (coil_pattern),
    .busy_res_i         (busy),
    .steps_completed_i  (steps_completed),
    .steps_requested_i  (steps_requested),
    .moving_direction_i (moving_direction),
    .cmd_accepted_i     (cmd_accepted),
    .move_finished_i    (move_finished),
    .fail_count_o       (fail_count),
    .pending_o          (pending),
    .results_o          (results_seen),
    .finished_o         (moves_finished)
  );

  // result side back-pressure, redrawn every cycle
  always @(negedge clk) begin
    res_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $error("watchdog: run not done within %0d cycles", CYCLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // one event transfer; called and returning at a falling edge
  task automatic send_event(input logic [FUNC_BITS-1:0] f,
                            input logic [STEP_COUNT_BITS-1:0] cnt, input logic dir);
    // random sender gap, valid low
    while ($urandom_range(99) < send_idle_pct) begin
      ev_valid <= 1'b0;
      @(negedge clk);
    end
    ev_valid <= 1'b1;
    ev_func  <= f;
    ev_count <= cnt;
    ev_dir   <= dir;
    @(posedge clk);
    while (!ev_ready) @(posedge clk);
    @(negedge clk);
    events_sent++;
  endtask

  // register write once every predicted status has come back
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    ev_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_STEP_DELAY) delay_setting = val;
    else driver_on = val[0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // driver still off after reset: motion rejected, release and stop leave coils alone
    send_event(FUNC_MOVE, 24'd5, DIR_CW);
    send_event(FUNC_STEP, '0, DIR_CW);
    send_event(FUNC_TICK, '0, DIR_CW);
    send_event(FUNC_RELEASE, COUNT_MAX, DIR_CCW);
    send_event(FUNC_STOP, '0, DIR_CCW);

    // zero delay behaves as a delay of one
    write_reg(CFG_DRIVER_ENABLE, CFG_ON);
    write_reg(CFG_STEP_DELAY, '0);
    send_event(FUNC_STEP, '0, DIR_CW);
    send_event(FUNC_STEP, '0, DIR_CCW);
    send_event(FUNC_STEP, '0, DIR_CCW);       // phase wraps below zero
    send_event(FUNC_MOVE, '0, DIR_CW);        // zero-step move completes on the spot
    send_event(FUNC_MOVE, 24'd2, DIR_CW);
    send_event(FUNC_MOVE, 24'd3, DIR_CCW);    // busy, so not taken
    send_event(FUNC_STEP, '0, DIR_CCW);       // single step inside a move
    send_event(FUNC_RELEASE, '0, DIR_CW);     // release does not stop the move
    send_event(FUNC_TICK, '0, DIR_CW);
    send_event(FUNC_TICK, '0, DIR_CW);        // move completes here
    for (spare = FUNC_SPARE_FIRST; spare <= FUNC_SPARE_LAST; spare++) begin
      send_event(FUNC_BITS'(spare), COUNT_MAX, DIR_CCW);
    end

    // longest delay with the largest count, aborted by stop
    write_reg(CFG_STEP_DELAY, DELAY_MAX);
    send_event(FUNC_MOVE, COUNT_MAX, DIR_CCW);
    send_event(FUNC_TICK, '0, DIR_CW);
    send_event(FUNC_STOP, COUNT_MAX, DIR_CW);

    // driver switched off mid-move: ticks count steps, coils and phase hold
    write_reg(CFG_STEP_DELAY, CFG_DATA_BITS'(1));
    send_event(FUNC_MOVE, 24'd3, DIR_CW);
    write_reg(CFG_DRIVER_ENABLE, CFG_OFF);
    repeat (3) send_event(FUNC_TICK, '0, DIR_CW);
    write_reg(CFG_DRIVER_ENABLE, CFG_ON);

    // random part in three idle mixes: slow receiver, slow sender, full rate
    random_base = events_sent;
    for (seg = 0; seg < 3; seg++) begin
      case (seg)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 78;
        end
        1: begin
          send_idle_pct = 78;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      while (events_sent < random_base + (seg + 1) * SEGMENT_EVENTS) begin
        // occasional reconfiguration between sequences, short delays keep moves short
        if ($urandom_range(11) == 0) begin
          write_reg(CFG_STEP_DELAY, CFG_DATA_BITS'($urandom_range(4)));
        end
        if (driver_on && $urandom_range(24) == 0) write_reg(CFG_DRIVER_ENABLE, CFG_OFF);
        else if (!driver_on && $urandom_range(2) == 0) write_reg(CFG_DRIVER_ENABLE, CFG_ON);

        pick = $urandom_range(99);
        if (pick < 70) begin
          // well-formed move: enough ticks to complete, sometimes a stop part way
          steps    = $urandom_range(1, 6);
          ticks    = steps * ((delay_setting == '0) ? 1 : delay_setting);
          span     = ticks + $urandom_range(2);
          abort_at = ($urandom_range(9) == 0) ? $urandom_range(ticks - 1) : span;
          send_event(FUNC_MOVE, STEP_COUNT_BITS'(steps), 1'($urandom_range(1)));
          for (j = 0; j < span; j++) begin
            if (j == abort_at) begin
              send_event(FUNC_STOP, STEP_COUNT_BITS'($urandom), 1'($urandom_range(1)));
            end else begin
              // extra commands only while the move is surely still running
              if (j + 1 < ticks) begin
                case ($urandom_range(15))
                  0: send_event(FUNC_STEP, STEP_COUNT_BITS'($urandom),
                                1'($urandom_range(1)));
                  1: send_event(FUNC_RELEASE, STEP_COUNT_BITS'($urandom),
                                1'($urandom_range(1)));
                  2: send_event(FUNC_MOVE, STEP_COUNT_BITS'($urandom),
                                1'($urandom_range(1)));
                  default: ;
                endcase
              end
              send_event(FUNC_TICK, STEP_COUNT_BITS'($urandom), 1'($urandom_range(1)));
            end
          end
        end else if (pick < 85) begin
          // noise over every func code and full-width counts, mostly cleaned up by a stop
          n = $urandom_range(1, 6);
          for (j = 0; j < n; j++) begin
            send_event(FUNC_BITS'($urandom_range(FUNC_SPARE_LAST)),
                       STEP_COUNT_BITS'($urandom), 1'($urandom_range(1)));
          end
          if ($urandom_range(3) != 0) begin
            send_event(FUNC_STOP, STEP_COUNT_BITS'($urandom), 1'($urandom_range(1)));
          end
        end else begin
          // single steps in both directions with some releases
          n = $urandom_range(1, 8);
          for (j = 0; j < n; j++) begin
            send_event(($urandom_range(3) == 0) ? FUNC_RELEASE : FUNC_STEP,
                       STEP_COUNT_BITS'($urandom), 1'($urandom_range(1)));
          end
        end
      end
    end

    // drain, then a short settle for anything unexpected
    ev_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("covered %0d event transfers over three idle mixes, %0d results checked,",
             events_sent, results_seen);
    $display("%0d moves completed, register writes at delay extremes and driver on and off",
             moves_finished);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
design/shc_pkg.sv
design/shc_step_logic.sv
design/stepper_half_step_controller.sv
design/shc_checker.sv
bench/shc_motion_checker.sv
bench/tb_stepper_half_step_controller.sv
